/* src/osw_pkg.sv */
// Shared constants and types for the obstacle scan wander controller.
`timescale 1ns / 1ps

package osw_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned MODE_W  = 4;
    localparam int unsigned CMD_W   = 4;
    localparam int unsigned SLOT_W  = 2;
    localparam int unsigned CFG_N   = 8;
    localparam int unsigned CFG_IDX_W = $clog2(CFG_N);

    typedef logic [DATA_W-1:0]    t_data;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_STOP_DISTANCE  = 3'd0;
    localparam t_cfg_idx CFG_TURN_CLEARANCE = 3'd1;
    localparam t_cfg_idx CFG_BACKUP_MS      = 3'd2;
    localparam t_cfg_idx CFG_LEFT_TURN_MS   = 3'd3;
    localparam t_cfg_idx CFG_RIGHT_TURN_MS  = 3'd4;
    localparam t_cfg_idx CFG_HEAD_LEFT_MS   = 3'd5;
    localparam t_cfg_idx CFG_HEAD_RIGHT_MS  = 3'd6;
    localparam t_cfg_idx CFG_HEAD_CENTER_MS = 3'd7;

    // Configuration reset values
    localparam t_data RST_STOP_DISTANCE  = 16'd40;
    localparam t_data RST_TURN_CLEARANCE = 16'd30;
    localparam t_data RST_BACKUP_MS      = 16'd5000;
    localparam t_data RST_LEFT_TURN_MS   = 16'd10000;
    localparam t_data RST_RIGHT_TURN_MS  = 16'd10000;
    localparam t_data RST_HEAD_LEFT_MS   = 16'd4000;
    localparam t_data RST_HEAD_RIGHT_MS  = 16'd8000;
    localparam t_data RST_HEAD_CENTER_MS = 16'd4000;

    // Modes
    localparam t_mode M_FWD     = 4'd0;
    localparam t_mode M_BACK    = 4'd1;
    localparam t_mode M_LEFT    = 4'd2;
    localparam t_mode M_RIGHT   = 4'd3;
    localparam t_mode M_HEADL   = 4'd4;
    localparam t_mode M_HEADR   = 4'd5;
    localparam t_mode M_HEADC   = 4'd6;
    localparam t_mode M_MEASURE = 4'd7;
    localparam t_mode M_SELECT  = 4'd8;
    localparam t_mode M_ERROR   = 4'd9;

    // Motion commands
    localparam t_cmd C_NONE    = 4'd0;
    localparam t_cmd C_STOP    = 4'd1;
    localparam t_cmd C_FWD     = 4'd2;
    localparam t_cmd C_BACK    = 4'd3;
    localparam t_cmd C_FLEFT   = 4'd4;
    localparam t_cmd C_FRIGHT  = 4'd5;
    localparam t_cmd C_HLEFT   = 4'd6;
    localparam t_cmd C_HRIGHT  = 4'd7;
    localparam t_cmd C_HCENTER = 4'd8;

    // Range slots
    localparam t_slot SLOT_NONE   = 2'd0;
    localparam t_slot SLOT_LEFT   = 2'd1;
    localparam t_slot SLOT_RIGHT  = 2'd2;
    localparam t_slot SLOT_CENTER = 2'd3;

endpackage

/* src/osw_in_if.sv */
// Input channel: one update tick per item.
`timescale 1ns / 1ps

interface osw_in_if;
    logic           valid;
    logic           ready;
    osw_pkg::t_data elapsed_ms;
    osw_pkg::t_data range_reading;
    logic           restart;

    modport source (output valid, elapsed_ms, range_reading, restart, input ready);
    modport sink   (input valid, elapsed_ms, range_reading, restart, output ready);
endinterface

/* src/osw_out_if.sv */
// Output channel: motion command and mode after the tick.
`timescale 1ns / 1ps

interface osw_out_if;
    logic           valid;
    logic           ready;
    osw_pkg::t_cmd  motion_cmd;
    osw_pkg::t_mode next_mode;

    modport source (output valid, motion_cmd, next_mode, input ready);
    modport sink   (input valid, motion_cmd, next_mode, output ready);
endinterface

/* src/obstacle_scan_wander_controller.sv */
// Top level: tick-driven drive / head-scan / turn state machine.
`timescale 1ns / 1ps

// Each accepted item is one update tick and yields exactly one result item
// (motion command plus the mode after the tick). The tick is evaluated in the
// cycle it is accepted and its result lands in the output register at that
// edge, and one item is taken every cycle as long as
// the output register is empty or being drained in the same cycle. The timer
// adds elapsed_ms and saturates at 65535 before the mode acts. Configuration
// registers are written through i_cfg_we / i_cfg_index / i_cfg_wdata and take
// effect on the next tick; write them only while no tick is in flight.
module obstacle_scan_wander_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    osw_in_if.sink              i_item,
    osw_out_if.source           o_result,
    input  logic                i_cfg_we,
    input  osw_pkg::t_cfg_idx   i_cfg_index,
    input  osw_pkg::t_data      i_cfg_wdata
);

    // Configuration
    osw_pkg::t_data r_stop_distance, r_turn_clearance, r_backup_ms;
    osw_pkg::t_data r_left_turn_ms, r_right_turn_ms;
    osw_pkg::t_data r_head_left_ms, r_head_right_ms, r_head_center_ms;

    // Controller state
    osw_pkg::t_mode r_mode,         n_mode;
    osw_pkg::t_data r_timer,        n_timer;
    osw_pkg::t_data r_left_range,   n_left_range;
    osw_pkg::t_data r_right_range,  n_right_range;
    osw_pkg::t_data r_center_range, n_center_range;
    osw_pkg::t_slot r_slot,         n_slot;

    // Output register
    logic           r_out_valid;
    osw_pkg::t_cmd  r_motion_cmd,   n_motion_cmd;

    logic                        accept;
    logic [osw_pkg::DATA_W:0]    timer_sum;
    osw_pkg::t_data              timer_acc;

    // Output register frees up when empty or drained this cycle.
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    assign o_result.valid      = r_out_valid;
    assign o_result.motion_cmd = r_motion_cmd;
    assign o_result.next_mode  = r_mode;

    // Saturating timer accumulate happens first on every tick.
    assign timer_sum = {1'b0, r_timer} + {1'b0, i_item.elapsed_ms};
    assign timer_acc = timer_sum[osw_pkg::DATA_W] ? '1 : timer_sum[osw_pkg::DATA_W-1:0];

    always_comb begin
        n_mode         = r_mode;
        n_timer        = timer_acc;
        n_left_range   = r_left_range;
        n_right_range  = r_right_range;
        n_center_range = r_center_range;
        n_slot         = r_slot;
        n_motion_cmd   = osw_pkg::C_NONE;

        if (i_item.restart) begin
            // Restart: timer still accumulates, nothing else acts.
            n_motion_cmd = osw_pkg::C_NONE;
            n_mode       = osw_pkg::M_FWD;
        end else begin
            unique case (r_mode)
                osw_pkg::M_FWD: begin
                    if (i_item.range_reading < r_stop_distance) begin
                        n_motion_cmd = osw_pkg::C_STOP;
                        n_mode       = osw_pkg::M_HEADL;
                        n_timer      = '0;
                    end else begin
                        n_motion_cmd = osw_pkg::C_FWD;
                    end
                end
                osw_pkg::M_BACK: begin
                    if (timer_acc >= r_backup_ms) begin
                        n_motion_cmd = osw_pkg::C_STOP;
                        n_mode       = osw_pkg::M_HEADL;
                        n_timer      = '0;
                    end else begin
                        n_motion_cmd = osw_pkg::C_BACK;
                    end
                end
                // Turns end without clearing the timer.
                osw_pkg::M_LEFT: begin
                    if (timer_acc >= r_left_turn_ms) begin
                        n_motion_cmd = osw_pkg::C_STOP;
                        n_mode       = osw_pkg::M_FWD;
                    end else begin
                        n_motion_cmd = osw_pkg::C_FLEFT;
                    end
                end
                osw_pkg::M_RIGHT: begin
                    if (timer_acc >= r_right_turn_ms) begin
                        n_motion_cmd = osw_pkg::C_STOP;
                        n_mode       = osw_pkg::M_FWD;
                    end else begin
                        n_motion_cmd = osw_pkg::C_FRIGHT;
                    end
                end
                // Head waits hand off to measure with the slot to fill.
                osw_pkg::M_HEADL: begin
                    if (timer_acc >= r_head_left_ms) begin
                        n_motion_cmd = osw_pkg::C_STOP;
                        n_slot       = osw_pkg::SLOT_LEFT;
                        n_mode       = osw_pkg::M_MEASURE;
                    end else begin
                        n_motion_cmd = osw_pkg::C_HLEFT;
                    end
                end
                osw_pkg::M_HEADR: begin
                    if (timer_acc >= r_head_right_ms) begin
                        n_motion_cmd = osw_pkg::C_STOP;
                        n_slot       = osw_pkg::SLOT_RIGHT;
                        n_mode       = osw_pkg::M_MEASURE;
                    end else begin
                        n_motion_cmd = osw_pkg::C_HRIGHT;
                    end
                end
                osw_pkg::M_HEADC: begin
                    if (timer_acc >= r_head_center_ms) begin
                        n_motion_cmd = osw_pkg::C_STOP;
                        n_slot       = osw_pkg::SLOT_CENTER;
                        n_mode       = osw_pkg::M_MEASURE;
                    end else begin
                        n_motion_cmd = osw_pkg::C_HCENTER;
                    end
                end
                osw_pkg::M_MEASURE: begin
                    n_motion_cmd = osw_pkg::C_NONE;
                    unique case (r_slot)
                        osw_pkg::SLOT_LEFT: begin
                            n_left_range = i_item.range_reading;
                            n_mode       = osw_pkg::M_HEADR;
                            n_timer      = '0;
                        end
                        osw_pkg::SLOT_RIGHT: begin
                            n_right_range = i_item.range_reading;
                            n_mode        = osw_pkg::M_HEADC;
                            n_timer       = '0;
                        end
                        osw_pkg::SLOT_CENTER: begin
                            n_center_range = i_item.range_reading;
                            n_mode         = osw_pkg::M_SELECT;
                            n_timer        = '0;
                        end
                        osw_pkg::SLOT_NONE: begin
                            // No slot pending: error, timer kept.
                            n_mode = osw_pkg::M_ERROR;
                        end
                    endcase
                end
                osw_pkg::M_SELECT: begin
                    n_motion_cmd = osw_pkg::C_NONE;
                    n_timer      = '0;
                    priority if (r_center_range < r_turn_clearance) begin
                        n_mode = osw_pkg::M_BACK;
                    end else if (r_left_range < r_turn_clearance &&
                                 r_right_range < r_turn_clearance) begin
                        n_mode = osw_pkg::M_BACK;
                    end else if (r_left_range >= r_right_range) begin
                        n_mode = osw_pkg::M_LEFT;
                    end else begin
                        n_mode = osw_pkg::M_RIGHT;
                    end
                end
                default: begin
                    // Error mode and unused codes recover to forward.
                    n_motion_cmd = osw_pkg::C_STOP;
                    n_mode       = osw_pkg::M_FWD;
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_distance  <= osw_pkg::RST_STOP_DISTANCE;
            r_turn_clearance <= osw_pkg::RST_TURN_CLEARANCE;
            r_backup_ms      <= osw_pkg::RST_BACKUP_MS;
            r_left_turn_ms   <= osw_pkg::RST_LEFT_TURN_MS;
            r_right_turn_ms  <= osw_pkg::RST_RIGHT_TURN_MS;
            r_head_left_ms   <= osw_pkg::RST_HEAD_LEFT_MS;
            r_head_right_ms  <= osw_pkg::RST_HEAD_RIGHT_MS;
            r_head_center_ms <= osw_pkg::RST_HEAD_CENTER_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                osw_pkg::CFG_STOP_DISTANCE:  r_stop_distance  <= i_cfg_wdata;
                osw_pkg::CFG_TURN_CLEARANCE: r_turn_clearance <= i_cfg_wdata;
                osw_pkg::CFG_BACKUP_MS:      r_backup_ms      <= i_cfg_wdata;
                osw_pkg::CFG_LEFT_TURN_MS:   r_left_turn_ms   <= i_cfg_wdata;
                osw_pkg::CFG_RIGHT_TURN_MS:  r_right_turn_ms  <= i_cfg_wdata;
                osw_pkg::CFG_HEAD_LEFT_MS:   r_head_left_ms   <= i_cfg_wdata;
                osw_pkg::CFG_HEAD_RIGHT_MS:  r_head_right_ms  <= i_cfg_wdata;
                osw_pkg::CFG_HEAD_CENTER_MS: r_head_center_ms <= i_cfg_wdata;
            endcase
        end
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= osw_pkg::M_FWD;
            r_timer        <= '0;
            r_left_range   <= '0;
            r_right_range  <= '0;
            r_center_range <= '0;
            r_slot         <= osw_pkg::SLOT_NONE;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_mode         <= n_mode;
                r_timer        <= n_timer;
                r_left_range   <= n_left_range;
                r_right_range  <= n_right_range;
                r_center_range <= n_center_range;
                r_slot         <= n_slot;
                r_out_valid    <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_motion_cmd <= n_motion_cmd;
        end
    end

endmodule

/* dv/tb_obstacle_scan_wander_controller.sv */
// Self-checking testbench for the obstacle scan wander controller.
`timescale 1ns / 1ps

module tb_obstacle_scan_wander_controller;
    import osw_pkg::*;

    localparam int DIR_N          = 25;
    localparam int PHASE_N        = 7;    // random phases after the directed part
    localparam int TICKS_PER_PHASE = 250;
    localparam int HOLD_CYCLES    = 300;  // long receiver hold-off to back up the input
    localparam int WATCHDOG_LIMIT = 2000; // cycles with no item moving on either side

    // One directed tick. Where typed is set, cmd/mode are the expected result as written
    // here; otherwise the scan model supplies the expectation.
    typedef struct packed {
        t_data elapsed;
        t_data rng;
        logic  rs;
        logic  typed;
        t_cmd  cmd;
        t_mode mode;
    } t_tick_row;

    typedef struct packed {
        t_cmd  cmd;
        t_mode mode;
    } t_move;

    // Walk every mode but right turn with the reset settings. Measure with no slot pending and
    // the unused mode codes cannot be reached once out of reset, so they are not driven.
    localparam t_tick_row DIRECTED [DIR_N] = '{
        '{16'd0,     16'd65535, 1'b0, 1'b1, C_FWD,  M_FWD},   // far range, keep driving
        '{16'd65535, 16'd40,    1'b0, 1'b1, C_FWD,  M_FWD},   // range equal to stop distance
        '{16'd65535, 16'd39,    1'b0, 1'b1, C_STOP, M_HEADL}, // just below, timer saturated
        '{16'd3999,  16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // head left, one short
        '{16'd1,     16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // head left reached
        '{16'd0,     16'd100,   1'b0, 1'b0, C_NONE, M_FWD},   // store left range
        '{16'd8000,  16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // head right reached
        '{16'd0,     16'd50,    1'b0, 1'b0, C_NONE, M_FWD},   // store right range
        '{16'd65535, 16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // head centre, saturated
        '{16'd0,     16'd30,    1'b0, 1'b0, C_NONE, M_FWD},   // centre equal to clearance
        '{16'd0,     16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // select: left wins
        '{16'd9999,  16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // left turn, one short
        '{16'd1,     16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // left turn done, timer kept
        '{16'd0,     16'd10,    1'b0, 1'b0, C_NONE, M_FWD},   // obstacle again
        '{16'd0,     16'd0,     1'b1, 1'b1, C_NONE, M_FWD},   // restart out of head left
        '{16'd0,     16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // obstacle at zero range
        '{16'd4000,  16'd0,     1'b0, 1'b0, C_NONE, M_FWD},
        '{16'd0,     16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // left range zero
        '{16'd8000,  16'd0,     1'b0, 1'b0, C_NONE, M_FWD},
        '{16'd0,     16'd65535, 1'b0, 1'b0, C_NONE, M_FWD},   // right range max
        '{16'd4000,  16'd0,     1'b0, 1'b0, C_NONE, M_FWD},
        '{16'd0,     16'd29,    1'b0, 1'b0, C_NONE, M_FWD},   // centre below clearance
        '{16'd0,     16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // select: back up
        '{16'd4999,  16'd0,     1'b0, 1'b0, C_NONE, M_FWD},   // backing, one short
        '{16'd1,     16'd0,     1'b0, 1'b0, C_NONE, M_FWD}    // backing done, rescan
    };

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_index;
    t_data    i_cfg_wdata;

    osw_in_if  tick_if ();
    osw_out_if move_if ();

    obstacle_scan_wander_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (tick_if),
        .o_result    (move_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Scan model state: its own copy of the registers and of the controller state.
    t_data cfg_reg [CFG_N];
    t_mode sm_mode;
    t_data sm_timer;
    t_data sm_left;
    t_data sm_right;
    t_data sm_center;
    t_slot sm_slot;

    t_move expected_moves [$];
    int    err_count;
    bit    idle_on;
    bit    hold_pending;
    int    stall_cycles;
    t_move got_move;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        err_count++;
    endtask

    // Advance the scan model by one tick and return the move it should produce.
    function automatic t_move scan_step(input t_data dt, input t_data rng, input logic rs);
        logic [DATA_W:0] sum;
        t_move           mv;
        sum = {1'b0, sm_timer} + {1'b0, dt};
        sm_timer = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
        mv.cmd  = C_NONE;
        mv.mode = sm_mode;
        if (rs) begin
            mv.mode = M_FWD;    // timer still accumulates, nothing else moves
        end else begin
            case (sm_mode)
                M_FWD: begin
                    if (rng < cfg_reg[CFG_STOP_DISTANCE]) begin
                        mv = '{C_STOP, M_HEADL};
                        sm_timer = '0;
                    end else begin
                        mv = '{C_FWD, M_FWD};
                    end
                end
                M_BACK: begin
                    if (sm_timer >= cfg_reg[CFG_BACKUP_MS]) begin
                        mv = '{C_STOP, M_HEADL};
                        sm_timer = '0;
                    end else begin
                        mv = '{C_BACK, M_BACK};
                    end
                end
                // turns end without clearing the timer
                M_LEFT:
                    mv = (sm_timer >= cfg_reg[CFG_LEFT_TURN_MS]) ? t_move'{C_STOP, M_FWD}
                                                                : t_move'{C_FLEFT, M_LEFT};
                M_RIGHT:
                    mv = (sm_timer >= cfg_reg[CFG_RIGHT_TURN_MS]) ? t_move'{C_STOP, M_FWD}
                                                                 : t_move'{C_FRIGHT, M_RIGHT};
                M_HEADL: begin
                    if (sm_timer >= cfg_reg[CFG_HEAD_LEFT_MS]) begin
                        mv = '{C_STOP, M_MEASURE};
                        sm_slot = SLOT_LEFT;
                    end else begin
                        mv = '{C_HLEFT, M_HEADL};
                    end
                end
                M_HEADR: begin
                    if (sm_timer >= cfg_reg[CFG_HEAD_RIGHT_MS]) begin
                        mv = '{C_STOP, M_MEASURE};
                        sm_slot = SLOT_RIGHT;
                    end else begin
                        mv = '{C_HRIGHT, M_HEADR};
                    end
                end
                M_HEADC: begin
                    if (sm_timer >= cfg_reg[CFG_HEAD_CENTER_MS]) begin
                        mv = '{C_STOP, M_MEASURE};
                        sm_slot = SLOT_CENTER;
                    end else begin
                        mv = '{C_HCENTER, M_HEADC};
                    end
                end
                M_MEASURE: begin
                    case (sm_slot)
                        SLOT_LEFT: begin
                            sm_left = rng;
                            mv.mode = M_HEADR;
                            sm_timer = '0;
                        end
                        SLOT_RIGHT: begin
                            sm_right = rng;
                            mv.mode = M_HEADC;
                            sm_timer = '0;
                        end
                        SLOT_CENTER: begin
                            sm_center = rng;
                            mv.mode = M_SELECT;
                            sm_timer = '0;
                        end
                        default: mv.mode = M_ERROR;  // nothing stored, timer kept
                    endcase
                end
                M_SELECT: begin
                    if (sm_center < cfg_reg[CFG_TURN_CLEARANCE])
                        mv.mode = M_BACK;
                    else if (sm_left < cfg_reg[CFG_TURN_CLEARANCE] &&
                             sm_right < cfg_reg[CFG_TURN_CLEARANCE])
                        mv.mode = M_BACK;
                    else if (sm_left >= sm_right)
                        mv.mode = M_LEFT;
                    else
                        mv.mode = M_RIGHT;
                    sm_timer = '0;
                end
                default: mv = '{C_STOP, M_FWD};  // error and unused codes
            endcase
        end
        sm_mode = mv.mode;
        return mv;
    endfunction

    // Offer one tick, starting and ending at a falling edge. valid stays high on exit so
    // back-to-back ticks need no second assignment in one step.
    task automatic send_tick(input t_data dt, input t_data rng, input logic rs,
                             input logic typed, input t_cmd tcmd, input t_mode tmode);
        t_move mv;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        tick_if.valid         <= 1'b1;
        tick_if.elapsed_ms    <= dt;
        tick_if.range_reading <= rng;
        tick_if.restart       <= rs;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
        mv = scan_step(dt, rng, rs);
        expected_moves.push_back(typed ? t_move'{tcmd, tmode} : mv);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every result is back; with one result per tick,
    // nothing is left in flight after that.
    task automatic drain_moves();
        tick_if.valid <= 1'b0;
        while (expected_moves.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_data val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        cfg_reg[idx] = val;
        @(negedge i_clk);
    endtask

    // Receiver: random ready bursts, plus one long hold-off on request.
    initial begin
        move_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                move_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                move_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                move_if.ready <= 1'b1;
            end
        end
    end

    // Result checker: compares each accepted move with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && move_if.valid === 1'b1 && move_if.ready === 1'b1) begin
            if (expected_moves.size() == 0) begin
                report_mismatch($sformatf("move cmd=%0d mode=%0d with no tick pending",
                                          move_if.motion_cmd, move_if.next_mode));
            end else begin
                got_move = expected_moves.pop_front();
                if (move_if.motion_cmd !== got_move.cmd)
                    report_mismatch($sformatf("motion_cmd %0d, expected %0d",
                                              move_if.motion_cmd, got_move.cmd));
                if (move_if.next_mode !== got_move.mode)
                    report_mismatch($sformatf("next_mode %0d, expected %0d",
                                              move_if.next_mode, got_move.mode));
            end
        end
    end

    // Watchdog: no item moving on either side for too long ends the run.
    always @(posedge i_clk) begin
        if ((tick_if.valid === 1'b1 && tick_if.ready === 1'b1) ||
            (move_if.valid === 1'b1 && move_if.ready === 1'b1)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int    near;
        int    span;
        int    peak;
        t_data dt;
        t_data rng;
        logic  rs;

        err_count    = 0;
        stall_cycles = 0;
        idle_on      = 1'b1;
        hold_pending = 1'b0;

        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_index           = CFG_STOP_DISTANCE;
        i_cfg_wdata           = '0;
        tick_if.valid         = 1'b0;
        tick_if.elapsed_ms    = '0;
        tick_if.range_reading = '0;
        tick_if.restart       = 1'b0;

        cfg_reg[CFG_STOP_DISTANCE]  = RST_STOP_DISTANCE;
        cfg_reg[CFG_TURN_CLEARANCE] = RST_TURN_CLEARANCE;
        cfg_reg[CFG_BACKUP_MS]      = RST_BACKUP_MS;
        cfg_reg[CFG_LEFT_TURN_MS]   = RST_LEFT_TURN_MS;
        cfg_reg[CFG_RIGHT_TURN_MS]  = RST_RIGHT_TURN_MS;
        cfg_reg[CFG_HEAD_LEFT_MS]   = RST_HEAD_LEFT_MS;
        cfg_reg[CFG_HEAD_RIGHT_MS]  = RST_HEAD_RIGHT_MS;
        cfg_reg[CFG_HEAD_CENTER_MS] = RST_HEAD_CENTER_MS;
        sm_mode   = M_FWD;
        sm_timer  = '0;
        sm_left   = '0;
        sm_right  = '0;
        sm_center = '0;
        sm_slot   = SLOT_NONE;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk with the reset settings
        for (int k = 0; k < DIR_N; k++)
            send_tick(DIRECTED[k].elapsed, DIRECTED[k].rng, DIRECTED[k].rs,
                      DIRECTED[k].typed, DIRECTED[k].cmd, DIRECTED[k].mode);
        drain_moves();

        // Random phases. Phase 1 zeros every register, phase 2 sets every register to
        // max, the middle phases pick random settings, the last goes back to reset values
        // and runs with no idling on either side.
        for (int p = 1; p <= PHASE_N; p++) begin
            idle_on = (p != PHASE_N);
            for (int r = CFG_STOP_DISTANCE; r <= CFG_HEAD_CENTER_MS; r++) begin
                if (p == 1)
                    write_reg(t_cfg_idx'(r), '0);
                else if (p == 2)
                    write_reg(t_cfg_idx'(r), '1);
                else if (p == PHASE_N)
                    write_reg(t_cfg_idx'(r), (r == CFG_STOP_DISTANCE)  ? RST_STOP_DISTANCE :
                                             (r == CFG_TURN_CLEARANCE) ? RST_TURN_CLEARANCE :
                                             (r == CFG_BACKUP_MS)      ? RST_BACKUP_MS :
                                             (r == CFG_LEFT_TURN_MS)   ? RST_LEFT_TURN_MS :
                                             (r == CFG_RIGHT_TURN_MS)  ? RST_RIGHT_TURN_MS :
                                             (r == CFG_HEAD_LEFT_MS)   ? RST_HEAD_LEFT_MS :
                                             (r == CFG_HEAD_RIGHT_MS)  ? RST_HEAD_RIGHT_MS :
                                                                         RST_HEAD_CENTER_MS);
                else if (r <= CFG_TURN_CLEARANCE)
                    // thresholds: mostly small so ranges straddle them
                    write_reg(t_cfg_idx'(r), ($urandom_range(0, 1) == 0)
                                             ? t_data'($urandom_range(0, 300))
                                             : t_data'($urandom_range(0, 65535)));
                else
                    // timings: mostly short so timed modes finish often
                    write_reg(t_cfg_idx'(r), ($urandom_range(0, 3) == 0)
                                             ? t_data'($urandom_range(0, 65535))
                                             : t_data'($urandom_range(0, 2000)));
            end
            i_cfg_we <= 1'b0;

            // small elapsed steps scaled to the longest wait, to land on the boundaries
            peak = 0;
            for (int r = CFG_BACKUP_MS; r <= CFG_HEAD_CENTER_MS; r++)
                if (int'(cfg_reg[r]) > peak) peak = int'(cfg_reg[r]);
            span = peak / 8 + 1;

            // long receiver hold-off so the output register fills and the input stalls
            if (p == 3) hold_pending = 1'b1;

            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                case ($urandom_range(0, 7))
                    0:       dt = '0;
                    1:       dt = '1;
                    2, 3:    dt = t_data'($urandom_range(0, 65535));
                    default: dt = t_data'($urandom_range(0, span));
                endcase
                case ($urandom_range(0, 7))
                    0, 1, 2: begin
                        near = int'(($urandom_range(0, 1) == 0) ? cfg_reg[CFG_STOP_DISTANCE]
                                                                : cfg_reg[CFG_TURN_CLEARANCE])
                               + int'($urandom_range(0, 4)) - 2;
                        if (near < 0) near = 0;
                        if (near > 65535) near = 65535;
                        rng = t_data'(near);
                    end
                    3:       rng = '0;
                    4:       rng = '1;
                    default: rng = t_data'($urandom_range(0, 65535));
                endcase
                // restart is rare so full scan sequences get through
                rs = ($urandom_range(0, 31) == 0);
                send_tick(dt, rng, rs, 1'b0, C_NONE, M_FWD);
            end
            drain_moves();
        end

        // keep clocking to catch any stray result
        repeat (4) @(negedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
